// ===== rtl/srmt_pkg.sv =====
package srmt_pkg;

    // digit width of the partial-product multipliers
    localparam int DIG_W = 32;

    // multiplier latencies of the two product phases
    localparam int LAT_A = 6;
    localparam int LAT_B = 11;

    // quotient bits of the midpoint divide and result bits of the miss search
    localparam int DIV_BITS  = 33;
    localparam int MISS_BITS = 31;

    // internal word widths
    localparam int S_W = 63;   // s = d1 x d2
    localparam int G_W = 64;   // d2 x e, d1 x e
    localparam int E_W = 33;   // c1 - c2, c1 + c2
    localparam int Q_W = 125;  // s.s
    localparam int N_W = 127;  // s.(d x e)
    localparam int A_W = 96;   // s.e
    localparam int R_W = 160;  // midpoint numerator and remainder
    localparam int W_W = 160;  // running q*(2m-1) term of the miss search
    localparam int D_W = 194;  // miss search remainder

    // direction clamp, +/-1.0 in Q2.30
    localparam logic signed [31:0] DIR_POS = 32'sd1073741824;
    localparam logic signed [31:0] DIR_NEG = -32'sd1073741824;

endpackage

// ===== rtl/srmt_mul.sv =====
module srmt_mul
    import srmt_pkg::*;
#(
    parameter int WA  = 64,
    parameter int WB  = 32,
    parameter int LAT = 6
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [WA-1:0]    a,
    input  logic signed [WB-1:0]    b,
    output logic signed [WA+WB-1:0] p
);

    localparam int NA  = (WA + DIG_W - 1) / DIG_W;
    localparam int NB  = (WB + DIG_W - 1) / DIG_W;
    localparam int NP  = NA * NB;
    localparam int WAP = NA * DIG_W;
    localparam int WBP = NB * DIG_W;
    localparam int WP  = WA + WB;

    logic [WA-1:0]  a_abs;
    logic [WB-1:0]  b_abs;
    logic [WAP-1:0] am_reg  [LAT-1];
    logic [WBP-1:0] bm_reg  [LAT-1];
    logic [WP-1:0]  acc_reg [LAT-1];
    logic           neg_reg [LAT-1];
    logic signed [WP-1:0] p_reg;

    // split operands into sign and magnitude
    assign a_abs = a[WA-1] ? -a : a;
    assign b_abs = b[WB-1] ? -b : b;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            am_reg[0]  <= WAP'(a_abs);
            bm_reg[0]  <= WBP'(b_abs);
            acc_reg[0] <= '0;
            neg_reg[0] <= a[WA-1] ^ b[WB-1];
        end
    end

    // one digit product accumulated per stage; stages past the last digit product pass the sum through
    for (genvar k = 1; k < LAT - 1; k++)
    begin : g_stage
        logic [WP-1:0] acc_next;

        if (k - 1 < NP)
        begin : g_pp
            localparam int I = (k - 1) / NB;
            localparam int J = (k - 1) % NB;
            logic [2*DIG_W-1:0] pp;

            assign pp = am_reg[k-1][I*DIG_W +: DIG_W] * bm_reg[k-1][J*DIG_W +: DIG_W];
            assign acc_next = acc_reg[k-1] + (WP'(pp) << (DIG_W * (I + J)));
        end
        else
        begin : g_pass
            assign acc_next = acc_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                am_reg[k]  <= am_reg[k-1];
                bm_reg[k]  <= bm_reg[k-1];
                acc_reg[k] <= acc_next;
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    // restore the sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= neg_reg[LAT-2] ? -$signed(acc_reg[LAT-2]) : $signed(acc_reg[LAT-2]);
        end
    end

    assign p = p_reg;

endmodule

// ===== rtl/stereo_ray_midpoint_triangulation.sv =====
// Channel  Direction  Handshake            Payload
// input    in         in_valid / in_stall  origin_a/b_x/y/z, dir_a/b_x/y/z
// output   out        out_valid/out_stall  point_x/y/z, miss_distance, status
//
// One request is taken every cycle unless the held result is stalled; each result
// passes through the two partial-product multiplier phases, then the 33-step restoring
// divide of the midpoint and the 31-step miss-distance search in parallel.
// Reset clears only the valid bits of the stages.
// A stalled result freezes the whole pipeline, so in_stall follows it.
module stereo_ray_midpoint_triangulation
    import srmt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] origin_a_x,
    input  logic signed [31:0] origin_a_y,
    input  logic signed [31:0] origin_a_z,
    input  logic signed [31:0] origin_b_x,
    input  logic signed [31:0] origin_b_y,
    input  logic signed [31:0] origin_b_z,
    input  logic signed [31:0] dir_a_x,
    input  logic signed [31:0] dir_a_y,
    input  logic signed [31:0] dir_a_z,
    input  logic signed [31:0] dir_b_x,
    input  logic signed [31:0] dir_b_y,
    input  logic signed [31:0] dir_b_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z,
    output logic [30:0]        miss_distance,
    output logic               status
);

    localparam int PST  = 3 + DIV_BITS;
    localparam int NSTG = 3 + LAT_A + 2 + LAT_B + PST + 1;
    localparam int NX1 [3] = '{1, 2, 0};
    localparam int NX2 [3] = '{2, 0, 1};
    localparam logic [DIV_BITS-1:0] SAT_NEG = DIV_BITS'(33'h0_8000_0000);
    localparam logic [DIV_BITS-1:0] SAT_POS = DIV_BITS'(33'h0_7FFF_FFFF);

    logic            adv;
    logic [NSTG-1:0] vld_reg;

    logic signed [31:0] c1_in [3];
    logic signed [31:0] c2_in [3];
    logic signed [31:0] d1_in [3];
    logic signed [31:0] d2_in [3];

    logic signed [31:0]    d1_1_reg [3];
    logic signed [31:0]    d2_1_reg [3];
    logic signed [E_W-1:0] e_1_reg  [3];
    logic signed [E_W-1:0] h_1_reg  [3];

    logic signed [63:0]    ps_2_reg  [3][2];
    logic signed [64:0]    pg1_2_reg [3][2];
    logic signed [64:0]    pg2_2_reg [3][2];
    logic signed [31:0]    d1_2_reg  [3];
    logic signed [31:0]    d2_2_reg  [3];
    logic signed [E_W-1:0] e_2_reg   [3];
    logic signed [E_W-1:0] h_2_reg   [3];

    logic signed [S_W-1:0] s_3_reg  [3];
    logic signed [G_W-1:0] g1_3_reg [3];
    logic signed [G_W-1:0] g2_3_reg [3];
    logic signed [31:0]    d1_3_reg [3];
    logic signed [31:0]    d2_3_reg [3];
    logic signed [E_W-1:0] e_3_reg  [3];
    logic signed [E_W-1:0] h_3_reg  [3];

    logic signed [E_W-1:0] ha_reg  [LAT_A][3];
    logic signed [31:0]    d1a_reg [LAT_A][3];
    logic signed [31:0]    d2a_reg [LAT_A][3];
    logic [LAT_A-1:0]      singa_reg;

    logic signed [2*S_W-1:0]   qp  [3];
    logic signed [S_W+G_W-1:0] n1p [3];
    logic signed [S_W+G_W-1:0] n2p [3];
    logic signed [S_W+E_W-1:0] ap  [3];

    logic signed [Q_W-1:0] qt_x1_reg, qr_x1_reg;
    logic signed [N_W-1:0] n1t_x1_reg, n1r_x1_reg, n2t_x1_reg, n2r_x1_reg;
    logic signed [A_W-1:0] at_x1_reg, ar_x1_reg;
    logic signed [E_W-1:0] h_x1_reg  [3];
    logic signed [31:0]    d1_x1_reg [3];
    logic signed [31:0]    d2_x1_reg [3];
    logic                  sing_x1_reg;

    logic signed [Q_W-1:0] q_x2_reg;
    logic signed [N_W-1:0] n1_x2_reg, n2_x2_reg;
    logic signed [A_W-1:0] a_x2_reg;
    logic signed [E_W-1:0] h_x2_reg  [3];
    logic signed [31:0]    d1_x2_reg [3];
    logic signed [31:0]    d2_x2_reg [3];
    logic                  sing_x2_reg;

    logic signed [Q_W+E_W-1:0] qh_p  [3];
    logic signed [N_W+31:0]    n1d_p [3];
    logic signed [N_W+31:0]    n2d_p [3];
    logic signed [2*A_W-1:0]   aa_p;
    logic signed [Q_W-1:0]     qb_reg [LAT_B];
    logic [LAT_B-1:0]          singb_reg;

    logic signed [Q_W-1:0] q_p_reg [PST];
    logic [PST-1:0]        sing_p_reg;
    logic signed [R_W-1:0] t_reg   [3];
    logic signed [N_W+31:0] r_reg  [3];
    logic signed [R_W-1:0] num_reg [3];
    logic [R_W-1:0]        rem_reg [3][2:PST-1];
    logic [DIV_BITS-1:0]   quo_reg [3][2:PST-1];
    logic                  neg_reg [3][2:PST-1];
    logic [R_W-1:0]        div_sub [3:PST-1];
    logic [R_W:0]          div_dif [3][3:PST-1];

    logic signed [D_W-1:0] dm_reg [0:MISS_BITS];
    logic signed [W_W-1:0] wm_reg [0:MISS_BITS];
    logic [MISS_BITS-1:0]  m_reg  [0:PST-1];
    logic signed [W_W-1:0] ms_t    [1:MISS_BITS];
    logic signed [D_W-1:0] ms_cand [1:MISS_BITS];

    logic signed [31:0]   pt_next [3];
    logic signed [31:0]   pt_reg  [3];
    logic [MISS_BITS-1:0] miss_reg;
    logic                 status_reg;

    function automatic logic signed [31:0] clamp_dir(input logic signed [31:0] v);
        logic signed [31:0] r;
        if (v > DIR_POS)
        begin
            r = DIR_POS;
        end
        else if (v < DIR_NEG)
        begin
            r = DIR_NEG;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    assign c1_in[0] = origin_a_x;
    assign c1_in[1] = origin_a_y;
    assign c1_in[2] = origin_a_z;
    assign c2_in[0] = origin_b_x;
    assign c2_in[1] = origin_b_y;
    assign c2_in[2] = origin_b_z;
    assign d1_in[0] = dir_a_x;
    assign d1_in[1] = dir_a_y;
    assign d1_in[2] = dir_a_z;
    assign d2_in[0] = dir_b_x;
    assign d2_in[1] = dir_b_y;
    assign d2_in[2] = dir_b_z;

    // advance the whole pipeline unless the held result is stalled
    assign adv      = !(vld_reg[NSTG-1] && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    // capture: clamp directions, form origin difference and sum
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                d1_1_reg[k] <= clamp_dir(d1_in[k]);
                d2_1_reg[k] <= clamp_dir(d2_in[k]);
                e_1_reg[k]  <= E_W'(c1_in[k]) - E_W'(c2_in[k]);
                h_1_reg[k]  <= E_W'(c1_in[k]) + E_W'(c2_in[k]);
            end
        end
    end

    // cross product terms
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ps_2_reg[k][0]  <= d1_1_reg[NX1[k]] * d2_1_reg[NX2[k]];
                ps_2_reg[k][1]  <= d1_1_reg[NX2[k]] * d2_1_reg[NX1[k]];
                pg1_2_reg[k][0] <= d2_1_reg[NX1[k]] * e_1_reg[NX2[k]];
                pg1_2_reg[k][1] <= d2_1_reg[NX2[k]] * e_1_reg[NX1[k]];
                pg2_2_reg[k][0] <= d1_1_reg[NX1[k]] * e_1_reg[NX2[k]];
                pg2_2_reg[k][1] <= d1_1_reg[NX2[k]] * e_1_reg[NX1[k]];
                d1_2_reg[k]     <= d1_1_reg[k];
                d2_2_reg[k]     <= d2_1_reg[k];
                e_2_reg[k]      <= e_1_reg[k];
                h_2_reg[k]      <= h_1_reg[k];
            end
        end
    end

    // cross product differences
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s_3_reg[k]  <= S_W'(ps_2_reg[k][0] - ps_2_reg[k][1]);
                g1_3_reg[k] <= G_W'(pg1_2_reg[k][0] - pg1_2_reg[k][1]);
                g2_3_reg[k] <= G_W'(pg2_2_reg[k][0] - pg2_2_reg[k][1]);
                d1_3_reg[k] <= d1_2_reg[k];
                d2_3_reg[k] <= d2_2_reg[k];
                e_3_reg[k]  <= e_2_reg[k];
                h_3_reg[k]  <= h_2_reg[k];
            end
        end
    end

    // dot product terms
    for (genvar k = 0; k < 3; k++)
    begin : g_dot
        srmt_mul #(.WA(S_W), .WB(S_W), .LAT(LAT_A)) u_mul_q
        (
            .clk (clk), .en (adv), .a (s_3_reg[k]), .b (s_3_reg[k]), .p (qp[k])
        );
        srmt_mul #(.WA(S_W), .WB(G_W), .LAT(LAT_A)) u_mul_n1
        (
            .clk (clk), .en (adv), .a (s_3_reg[k]), .b (g1_3_reg[k]), .p (n1p[k])
        );
        srmt_mul #(.WA(S_W), .WB(G_W), .LAT(LAT_A)) u_mul_n2
        (
            .clk (clk), .en (adv), .a (s_3_reg[k]), .b (g2_3_reg[k]), .p (n2p[k])
        );
        srmt_mul #(.WA(S_W), .WB(E_W), .LAT(LAT_A)) u_mul_a
        (
            .clk (clk), .en (adv), .a (s_3_reg[k]), .b (e_3_reg[k]), .p (ap[k])
        );
    end

    // carry side data past the dot product multipliers; flag parallel rays or a zero direction
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ha_reg[0]    <= h_3_reg;
            d1a_reg[0]   <= d1_3_reg;
            d2a_reg[0]   <= d2_3_reg;
            singa_reg[0] <= (s_3_reg[0] == '0) && (s_3_reg[1] == '0) && (s_3_reg[2] == '0);
            for (int i = 1; i < LAT_A; i++)
            begin
                ha_reg[i]    <= ha_reg[i-1];
                d1a_reg[i]   <= d1a_reg[i-1];
                d2a_reg[i]   <= d2a_reg[i-1];
                singa_reg[i] <= singa_reg[i-1];
            end
        end
    end

    // sum the dot product terms over two stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qt_x1_reg   <= Q_W'(qp[0]) + Q_W'(qp[1]);
            qr_x1_reg   <= Q_W'(qp[2]);
            n1t_x1_reg  <= n1p[0] + n1p[1];
            n1r_x1_reg  <= n1p[2];
            n2t_x1_reg  <= n2p[0] + n2p[1];
            n2r_x1_reg  <= n2p[2];
            at_x1_reg   <= ap[0] + ap[1];
            ar_x1_reg   <= ap[2];
            h_x1_reg    <= ha_reg[LAT_A-1];
            d1_x1_reg   <= d1a_reg[LAT_A-1];
            d2_x1_reg   <= d2a_reg[LAT_A-1];
            sing_x1_reg <= singa_reg[LAT_A-1];

            q_x2_reg    <= qt_x1_reg + qr_x1_reg;
            n1_x2_reg   <= n1t_x1_reg + n1r_x1_reg;
            n2_x2_reg   <= n2t_x1_reg + n2r_x1_reg;
            a_x2_reg    <= at_x1_reg + ar_x1_reg;
            h_x2_reg    <= h_x1_reg;
            d1_x2_reg   <= d1_x1_reg;
            d2_x2_reg   <= d2_x1_reg;
            sing_x2_reg <= sing_x1_reg;
        end
    end

    // numerator terms and the squared miss term
    for (genvar k = 0; k < 3; k++)
    begin : g_num
        srmt_mul #(.WA(Q_W), .WB(E_W), .LAT(LAT_B)) u_mul_qh
        (
            .clk (clk), .en (adv), .a (q_x2_reg), .b (h_x2_reg[k]), .p (qh_p[k])
        );
        srmt_mul #(.WA(N_W), .WB(32), .LAT(LAT_B)) u_mul_n1d
        (
            .clk (clk), .en (adv), .a (n1_x2_reg), .b (d1_x2_reg[k]), .p (n1d_p[k])
        );
        srmt_mul #(.WA(N_W), .WB(32), .LAT(LAT_B)) u_mul_n2d
        (
            .clk (clk), .en (adv), .a (n2_x2_reg), .b (d2_x2_reg[k]), .p (n2d_p[k])
        );
    end

    srmt_mul #(.WA(A_W), .WB(A_W), .LAT(LAT_B)) u_mul_aa
    (
        .clk (clk), .en (adv), .a (a_x2_reg), .b (a_x2_reg), .p (aa_p)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qb_reg[0]    <= q_x2_reg;
            singb_reg[0] <= sing_x2_reg;
            for (int i = 1; i < LAT_B; i++)
            begin
                qb_reg[i]    <= qb_reg[i-1];
                singb_reg[i] <= singb_reg[i-1];
            end
        end
    end

    // trial subtractions of the divide and the miss search
    always_comb
    begin
        for (int k = 3; k < PST; k++)
        begin
            div_sub[k] = R_W'($unsigned(q_p_reg[k-1])) << (PST - k);
            for (int c = 0; c < 3; c++)
            begin
                div_dif[c][k] = {1'b0, rem_reg[c][k-1]} - {1'b0, div_sub[k]};
            end
        end
        for (int k = 1; k <= MISS_BITS; k++)
        begin
            ms_t[k]    = wm_reg[k-1] + (W_W'(q_p_reg[k-1]) << (MISS_BITS - k));
            ms_cand[k] = dm_reg[k-1] - (D_W'(ms_t[k]) << (MISS_BITS + 2 - k));
        end
    end

    // post stages: numerator sum, divide and miss search
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_p_reg[0]    <= qb_reg[LAT_B-1];
            sing_p_reg[0] <= singb_reg[LAT_B-1];
            for (int k = 1; k < PST; k++)
            begin
                q_p_reg[k]    <= q_p_reg[k-1];
                sing_p_reg[k] <= sing_p_reg[k-1];
            end

            for (int c = 0; c < 3; c++)
            begin
                t_reg[c]   <= R_W'(qh_p[c]) + R_W'(n1d_p[c]);
                r_reg[c]   <= n2d_p[c];
                num_reg[c] <= t_reg[c] + R_W'(r_reg[c]);

                rem_reg[c][2] <= (num_reg[c][R_W-1] ? $unsigned(-num_reg[c])
                                                    : $unsigned(num_reg[c]))
                               + R_W'($unsigned(q_p_reg[1]));
                quo_reg[c][2] <= '0;
                neg_reg[c][2] <= num_reg[c][R_W-1];

                for (int k = 3; k < PST; k++)
                begin
                    neg_reg[c][k] <= neg_reg[c][k-1];
                    if (!div_dif[c][k][R_W])
                    begin
                        rem_reg[c][k] <= div_dif[c][k][R_W-1:0];
                        quo_reg[c][k] <= quo_reg[c][k-1]
                                       | (DIV_BITS'(1) << (PST - 1 - k));
                    end
                    else
                    begin
                        rem_reg[c][k] <= rem_reg[c][k-1];
                        quo_reg[c][k] <= quo_reg[c][k-1];
                    end
                end
            end

            dm_reg[0] <= (D_W'(aa_p) << 2) - D_W'(qb_reg[LAT_B-1]);
            wm_reg[0] <= -W_W'(qb_reg[LAT_B-1]);
            m_reg[0]  <= '0;
            for (int k = 1; k <= MISS_BITS; k++)
            begin
                if (!ms_cand[k][D_W-1])
                begin
                    dm_reg[k] <= ms_cand[k];
                    wm_reg[k] <= wm_reg[k-1] + (W_W'(q_p_reg[k-1]) << (MISS_BITS + 1 - k));
                    m_reg[k]  <= m_reg[k-1] | (MISS_BITS'(1) << (MISS_BITS - k));
                end
                else
                begin
                    dm_reg[k] <= dm_reg[k-1];
                    wm_reg[k] <= wm_reg[k-1];
                    m_reg[k]  <= m_reg[k-1];
                end
            end
            for (int k = MISS_BITS + 1; k < PST; k++)
            begin
                m_reg[k] <= m_reg[k-1];
            end
        end
    end

    // saturate the rounded midpoint and restore its sign
    always_comb
    begin
        logic [DIV_BITS-1:0] mag;
        for (int c = 0; c < 3; c++)
        begin
            mag = quo_reg[c][PST-1];
            if (neg_reg[c][PST-1])
            begin
                if (mag > SAT_NEG)
                begin
                    mag = SAT_NEG;
                end
                pt_next[c] = 32'(~mag + DIV_BITS'(1));
            end
            else
            begin
                if (mag > SAT_POS)
                begin
                    mag = SAT_POS;
                end
                pt_next[c] = 32'(mag);
            end
        end
    end

    // output register; parallel rays or a zero direction give zeros and status set
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                pt_reg[c] <= sing_p_reg[PST-1] ? '0 : pt_next[c];
            end
            miss_reg   <= sing_p_reg[PST-1] ? '0 : m_reg[PST-1];
            status_reg <= sing_p_reg[PST-1];
        end
    end

    assign out_valid     = vld_reg[NSTG-1];
    assign point_x       = pt_reg[0];
    assign point_y       = pt_reg[1];
    assign point_z       = pt_reg[2];
    assign miss_distance = miss_reg;
    assign status        = status_reg;

endmodule

// ===== verif/srmt_checker.sv =====
`timescale 1ns / 100ps

module srmt_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [11:0][31:0] req,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [31:0]       point_x,
    input  logic [31:0]       point_y,
    input  logic [31:0]       point_z,
    input  logic [30:0]       miss_distance,
    input  logic              status,
    output int                fail_count,
    output int                pending
);

    typedef logic signed [259:0] wint;

    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [30:0] miss;
        logic        singular;
    } midpoint_t;

    midpoint_t expected_points[$];

    function automatic wint clamp_dir(input logic [31:0] raw);
        wint v;
        v = wint'($signed(raw));
        if (v > wint'(1073741824))
            v = wint'(1073741824);
        if (v < -wint'(1073741824))
            v = -wint'(1073741824);
        return v;
    endfunction

    function automatic void cross3(input wint x[3], input wint y[3], output wint z[3]);
        z[0] = x[1] * y[2] - x[2] * y[1];
        z[1] = x[2] * y[0] - x[0] * y[2];
        z[2] = x[0] * y[1] - x[1] * y[0];
    endfunction

    // Midpoint of the two closest ray points, rounded and saturated, plus their separation
    function automatic midpoint_t triangulate(input logic [11:0][31:0] r);
        midpoint_t res;
        wint c1[3], c2[3], d1[3], d2[3], s[3], e[3], g1[3], g2[3];
        wint q, n1, n2, a, num, tgt, quo, a4, cand, u, m;
        logic neg;
        logic [31:0] pt[3];
        for (int k = 0; k < 3; k++)
        begin
            c1[k] = wint'($signed(r[k]));
            c2[k] = wint'($signed(r[3 + k]));
            d1[k] = clamp_dir(r[6 + k]);
            d2[k] = clamp_dir(r[9 + k]);
        end
        res = '{default: '0};
        cross3(d1, d2, s);
        if (s[0] == 0 && s[1] == 0 && s[2] == 0)
        begin
            res.singular = 1'b1;
            return res;
        end
        for (int k = 0; k < 3; k++)
            e[k] = c1[k] - c2[k];
        cross3(d2, e, g1);
        cross3(d1, e, g2);
        q  = s[0] * s[0] + s[1] * s[1] + s[2] * s[2];
        n1 = s[0] * g1[0] + s[1] * g1[1] + s[2] * g1[2];
        n2 = s[0] * g2[0] + s[1] * g2[1] + s[2] * g2[2];
        a  = s[0] * e[0] + s[1] * e[1] + s[2] * e[2];
        for (int k = 0; k < 3; k++)
        begin
            num = q * (c1[k] + c2[k]) + n1 * d1[k] + n2 * d2[k];
            neg = num < 0;
            if (neg)
                num = -num;
            // round half away from zero: floor((|num| + q) / 2q)
            tgt = num + q;
            quo = tgt / (q + q);
            if (neg)
            begin
                if (quo > wint'(64'h8000_0000))
                    quo = wint'(64'h8000_0000);
                quo = -quo;
            end
            else if (quo > wint'(64'h7FFF_FFFF))
                quo = wint'(64'h7FFF_FFFF);
            pt[k] = quo[31:0];
        end
        res.px = pt[0];
        res.py = pt[1];
        res.pz = pt[2];
        // largest m with (2m-1)^2 * q <= 4 a^2
        a4 = 4 * a * a;
        m = 0;
        for (int b = 30; b >= 0; b--)
        begin
            cand = m | (wint'(1) <<< b);
            u = 2 * cand - 1;
            if (u * u * q <= a4)
                m = cand;
        end
        res.miss = m[30:0];
        return res;
    endfunction

    assign pending = expected_points.size();

    // Predict on every accepted request, compare on every accepted result
    always @(posedge clk or negedge rst_n)
    begin
        midpoint_t exp_pt;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_points.push_back(triangulate(req));
            if (out_valid && !out_stall)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_pt = expected_points.pop_front();
                    if (point_x !== exp_pt.px || point_y !== exp_pt.py
                        || point_z !== exp_pt.pz || miss_distance !== exp_pt.miss
                        || status !== exp_pt.singular)
                        fail_count <= fail_count + 1;
                    if (point_x !== exp_pt.px)
                        $error("point_x expected %0d got %0d",
                               $signed(exp_pt.px), $signed(point_x));
                    if (point_y !== exp_pt.py)
                        $error("point_y expected %0d got %0d",
                               $signed(exp_pt.py), $signed(point_y));
                    if (point_z !== exp_pt.pz)
                        $error("point_z expected %0d got %0d",
                               $signed(exp_pt.pz), $signed(point_z));
                    if (miss_distance !== exp_pt.miss)
                        $error("miss_distance expected %0d got %0d",
                               exp_pt.miss, miss_distance);
                    if (status !== exp_pt.singular)
                        $error("status expected %0d got %0d", exp_pt.singular, status);
                end
            end
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int N_RANDOM   = 830;
    localparam int IDLE_PCT   = 29;
    localparam int DRAIN      = 120;
    localparam int STALL_LIM  = 3000;
    localparam logic [31:0] ONE = 32'h4000_0000;
    localparam logic [31:0] M_ONE = 32'hC000_0000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [11:0][31:0] req;
    logic              out_valid;
    logic              out_stall;
    logic signed [31:0] point_x, point_y, point_z;
    logic [30:0]       miss_distance;
    logic              status;
    logic              in_taken;
    logic              stim_done;
    int                fail_count, pending;
    int                quiet_cycles;

    stereo_ray_midpoint_triangulation dut
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .origin_a_x(req[0]), .origin_a_y(req[1]), .origin_a_z(req[2]),
        .origin_b_x(req[3]), .origin_b_y(req[4]), .origin_b_z(req[5]),
        .dir_a_x(req[6]), .dir_a_y(req[7]), .dir_a_z(req[8]),
        .dir_b_x(req[9]), .dir_b_y(req[10]), .dir_b_z(req[11]),
        .out_valid(out_valid), .out_stall(out_stall),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .miss_distance(miss_distance), .status(status)
    );

    srmt_checker chk
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .req(req),
        .out_valid(out_valid), .out_stall(out_stall),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .miss_distance(miss_distance), .status(status),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Record handshakes for the driver and the watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_taken     <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            in_taken  <= in_valid && !in_stall;
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // End the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_LIM)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stall results at random, with one long hold-off and one clean stretch
    initial
    begin
        int cyc;
        out_stall = 1'b0;
        cyc = 0;
        @(posedge rst_n);
        while (!stim_done || pending != 0)
        begin
            @(negedge clk);
            cyc++;
            if (cyc >= 400 && cyc < 700)
                out_stall <= 1'b1;
            else if (cyc >= 900 && cyc < 1300)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
        @(negedge clk);
        out_stall <= 1'b0;
    end

    function automatic logic [31:0] rand_dir();
        int pick;
        pick = $urandom_range(99);
        if (pick < 75)
            return 32'(longint'($urandom_range(32'h8000_0000)) - 64'd1073741824);
        if (pick < 88)
            return $urandom();
        if (pick < 94)
            return ($urandom_range(1) != 0) ? ONE : M_ONE;
        return 32'($signed($urandom_range(8)) - 4);
    endfunction

    function automatic logic [31:0] rand_origin();
        if ($urandom_range(99) < 60)
            return 32'(longint'($urandom_range(32'h0020_0000)) - 64'h0010_0000);
        return $urandom();
    endfunction

    // Offer one request, idling first at random unless no_gaps is set, and hold it until taken
    task automatic send_request(input logic [11:0][31:0] r, input bit no_gaps);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        req      <= r;
        in_valid <= 1'b1;
        do
            @(negedge clk);
        while (!in_taken);
    endtask

    initial
    begin
        logic [11:0][31:0] r;
        logic [11:0][31:0] directed[$];
        int kind;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        stim_done = 1'b0;
        req       = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // all zero: zero directions are singular
        directed.push_back('0);
        // perpendicular axis rays crossing
        r = '0; r[6] = ONE; r[10] = ONE; r[3] = 32'h0001_0000; directed.push_back(r);
        // skew axis rays, origins at the extremes
        r = '0; r[6] = ONE; r[11] = M_ONE;
        r[0] = 32'h7FFF_FFFF; r[1] = 32'h8000_0000; r[2] = 32'h7FFF_FFFF;
        r[3] = 32'h8000_0000; r[4] = 32'h7FFF_FFFF; r[5] = 32'h8000_0000;
        directed.push_back(r);
        // parallel, anti-parallel and scaled directions
        r = '0; r[6] = ONE; r[9] = ONE; r[4] = 32'h0005_0000; directed.push_back(r);
        r = '0; r[7] = ONE; r[10] = M_ONE; directed.push_back(r);
        r = '0; r[6] = 32'd1000; r[7] = 32'd2000; r[9] = 32'd2000; r[10] = 32'd4000;
        directed.push_back(r);
        // one zero direction
        r = '0; r[6] = ONE; r[1] = 32'h0003_0000; directed.push_back(r);
        // out-of-range directions clamp to +/-1.0
        r = '0; r[6] = 32'h7FFF_FFFF; r[10] = 32'h8000_0000; r[11] = 32'h7FFF_FFFF;
        r[2] = 32'h0010_0000; directed.push_back(r);
        r = '0; r[6] = 32'h8000_0000; r[7] = 32'h4000_0001; r[9] = 32'hBFFF_FFFF;
        r[11] = 32'h7FFF_FFFF; directed.push_back(r);
        // nearly parallel rays meet far away and saturate
        r = '0; r[6] = ONE; r[9] = ONE; r[10] = 32'd1; r[4] = 32'h7FFF_FFFF;
        directed.push_back(r);
        r = '0; r[6] = ONE; r[9] = ONE; r[10] = 32'hFFFF_FFFF; r[1] = 32'h7FFF_FFFF;
        r[4] = 32'h8000_0000; r[2] = 32'h8000_0000; directed.push_back(r);
        // far skew lines: miss distance saturates
        r = '0; r[6] = ONE; r[10] = ONE; r[2] = 32'h7FFF_FFFF; r[5] = 32'h8000_0000;
        directed.push_back(r);
        // smallest nonzero cross product
        r = '0; r[6] = 32'd1; r[10] = 32'd1; r[5] = 32'h0000_0001; directed.push_back(r);
        // diagonal directions, all bits of a direction toggled
        r = '0; r[6] = 32'h2D41_3CCD; r[7] = 32'h2D41_3CCD; r[9] = 32'hD2BE_C333;
        r[11] = 32'h2D41_3CCD; r[0] = 32'hFFFF_0000; directed.push_back(r);
        r = '0; r[7] = 32'h3FFF_FFFF; r[8] = 32'hC000_0001; r[9] = 32'h1555_5555;
        r[11] = 32'hEAAA_AAAB; r[3] = 32'h5555_5555; r[5] = 32'hAAAA_AAAA;
        directed.push_back(r);

        foreach (directed[i])
            send_request(directed[i], 1'b0);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            for (int k = 0; k < 6; k++)
                r[k] = rand_origin();
            for (int k = 6; k < 12; k++)
                r[k] = rand_dir();
            kind = $urandom_range(99);
            // same or opposite direction: parallel rays
            if (kind < 8)
                for (int k = 0; k < 3; k++)
                    r[9 + k] = (kind < 4) ? r[6 + k] : -r[6 + k];
            // shared origin: rays meet exactly
            else if (kind < 16)
                for (int k = 0; k < 3; k++)
                    r[3 + k] = r[k];
            // zero direction
            else if (kind < 19)
                for (int k = 0; k < 3; k++)
                    r[9 + k] = '0;
            send_request(r, n >= 300 && n < 450);
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
